// ===== rtl/bia_pkg.sv =====
// Shared types, codes and sizes for the bitmap id allocator.
package bia_pkg;

  localparam int MAX_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int BIT_IDX_W   = 6;
  localparam int WORD_IDX_W  = 2;
  localparam int ID_W        = WORD_IDX_W + BIT_IDX_W;
  localparam int CNT_W       = 3;
  localparam int ACT_W       = 2;
  localparam int STAT_W      = 2;

  localparam logic [CNT_W-1:0] WORDS_RESET = CNT_W'(MAX_WORDS);

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;   // take the request, issue the bitmap read
    logic exec;      // update the bitmap, load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;  // result register full and not drained this cycle
  } dp_status_t;

endpackage

// ===== rtl/bia_if.sv =====
// Request and response channel interfaces.
interface bia_in_if;
  import bia_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [ID_W-1:0]      slot_id;

  modport source (output valid, output action, output slot_id, input ready);
  modport sink   (input valid, input action, input slot_id, output ready);
endinterface

interface bia_out_if;
  import bia_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ID_W-1:0]      granted_id;

  modport source (output valid, output status, output granted_id, input ready);
  modport sink   (input valid, input status, input granted_id, output ready);
endinterface

// ===== rtl/bia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bia_ctrl.sv =====
// Request sequencer: accept, then execute, one request at a time.
module bia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bia_pkg::dp_status_t dp_status,
  output bia_pkg::ctrl_cmd_t  cmd
);
  import bia_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !dp_status.out_blocked;
        if (in_valid && !dp_status.out_blocked) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/bia_dp.sv =====
// Bitmap store, word search, bit update and result register.
module bia_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bia_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic [bia_pkg::ACT_W-1:0] in_action,
  input  logic [bia_pkg::ID_W-1:0]  in_slot_id,
  input  bia_pkg::ctrl_cmd_t        cmd,
  output bia_pkg::dp_status_t       dp_status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bia_pkg::STAT_W-1:0] out_status,
  output logic [bia_pkg::ID_W-1:0]  out_granted_id
);
  import bia_pkg::*;

  // Lowest clear bit: per-byte priority first, then pick the first non-full byte.
  function automatic logic [BIT_IDX_W-1:0] lowest_clear(input logic [WORD_W-1:0] w);
    logic [2:0] byte_pos [8];
    logic [7:0] byte_has;
    logic [2:0] sel;
    byte_has = '0;
    sel      = '0;
    for (int i = 0; i < 8; i++) begin
      byte_pos[i] = '0;
      for (int j = 7; j >= 0; j--) begin
        if (!w[i*8+j]) begin
          byte_pos[i] = 3'(j);
        end
      end
      byte_has[i] = !(&w[i*8 +: 8]);
    end
    for (int i = 7; i >= 0; i--) begin
      if (byte_has[i]) begin
        sel = 3'(i);
      end
    end
    return {sel, byte_pos[sel]};
  endfunction

  logic [CNT_W-1:0]      words_in_use;
  logic [MAX_WORDS-1:0]  word_valid;
  logic [MAX_WORDS-1:0]  word_full;

  logic [ACT_W-1:0]      act_q;
  logic [ID_W-1:0]       slot_q;
  logic [WORD_IDX_W-1:0] widx_q;
  logic                  found_q;

  logic [CNT_W-1:0]      n_act;
  logic [WORD_IDX_W-1:0] sel_w;
  logic                  any_free;
  logic [WORD_IDX_W-1:0] rd_idx;

  logic [WORD_W-1:0]     rdata;
  logic [WORD_W-1:0]     cur_word;
  logic [WORD_W-1:0]     new_word;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic                  in_range;
  logic                  ram_we;

  assign n_act = (words_in_use > WORDS_RESET) ? WORDS_RESET : words_in_use;

  // First non-full bitmap word among those in use.
  always_comb begin
    sel_w    = '0;
    any_free = 1'b0;
    for (int w = MAX_WORDS - 1; w >= 0; w--) begin
      if ((CNT_W'(w) < n_act) && !word_full[w]) begin
        sel_w    = WORD_IDX_W'(w);
        any_free = 1'b1;
      end
    end
  end

  assign rd_idx = (in_action == ACT_ALLOC) ? sel_w
                                           : in_slot_id[ID_W-1 -: WORD_IDX_W];

  bia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_q),
    .wdata (new_word),
    .re    (cmd.capture),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // A bitmap word never written since reset or clear reads as all free.
  assign cur_word = word_valid[widx_q] ? rdata : '0;
  assign in_range = {1'b0, slot_q} < {n_act, BIT_IDX_W'(0)};

  always_comb begin
    bit_idx  = lowest_clear(cur_word);
    new_word = cur_word;
    ram_we   = 1'b0;
    if (cmd.exec) begin
      if (act_q == ACT_ALLOC && found_q) begin
        new_word = cur_word | (WORD_W'(1) << bit_idx);
        ram_we   = 1'b1;
      end else if (act_q == ACT_FREE && in_range) begin
        new_word = cur_word & ~(WORD_W'(1) << slot_q[BIT_IDX_W-1:0]);
        ram_we   = 1'b1;
      end
    end
  end

  assign dp_status.out_blocked = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= WORDS_RESET;
      word_valid   <= '0;
      word_full    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        words_in_use <= cfg_wr_data;
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
        if (ram_we) begin
          word_valid[widx_q] <= 1'b1;
          word_full[widx_q]  <= &new_word;
        end else if (act_q == ACT_CLEAR) begin
          word_valid <= '0;
          word_full  <= '0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q   <= in_action;
      slot_q  <= in_slot_id;
      widx_q  <= rd_idx;
      found_q <= any_free;
    end
    if (cmd.exec) begin
      if (act_q == ACT_ALLOC && found_q) begin
        out_status     <= STAT_DONE;
        out_granted_id <= {widx_q, bit_idx};
      end else if (act_q == ACT_ALLOC) begin
        out_status     <= STAT_FULL;
        out_granted_id <= '0;
      end else if (act_q == ACT_FREE && !in_range) begin
        out_status     <= STAT_RANGE;
        out_granted_id <= '0;
      end else begin
        out_status     <= STAT_DONE;
        out_granted_id <= '0;
      end
    end
  end

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
// Top level of the bitmap id allocator: sequencer plus bitmap datapath.
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  -------------------------------------
//  in_ch    in   valid/ready    action[1:0], slot_id[7:0]
//  out_ch   out  valid/ready    status[1:0], granted_id[7:0]
//  cfg      in   cfg_wr_en      cfg_wr_data[2:0] -> words_in_use
//
// For each request, the accept cycle reads one bitmap word from
// the RAM (chosen by the per-word full flags or by the id), the next cycle
// writes the updated word back for an allocation or an in-range free, and
// loads the result register.
// Reset is synchronous; per-word valid flags make every bitmap word read as
// free right after reset or a clear request, with no clearing pass.
// A waiting result does not block acceptance while it is being drained;
// a new request is refused while one executes or the result register stays full.
module bitmap_id_allocator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bia_pkg::CNT_W-1:0] cfg_wr_data,
  bia_in_if.sink                    in_ch,
  bia_out_if.source                 out_ch
);
  import bia_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Sequencer: owns in_ch.ready and the capture/execute strobes.
  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // Datapath: bitmap RAM, full/valid flags, search and the result register.
  bia_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (in_ch.action),
    .in_slot_id     (in_ch.slot_id),
    .cmd            (cmd),
    .dp_status      (dp_status),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_granted_id (out_ch.granted_id)
  );

`ifndef ASSERT_OFF
  // Every accepted word is executed in the very next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> cmd.exec)
    else $error("accepted request not executed next cycle");

  // Execution always presents a result.
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_ch.valid)
    else $error("execute did not load a result");

  // Capture and execute never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.exec))
    else $error("capture during execute");

  // Acceptance only when the result register will be free for the result.
  a_room_for_result: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("ready while result register stays full");
`endif

endmodule
